// ----- sv/uvst_pkg.sv -----
// Package for the unique value set table: field widths, command and status
// codes, and the command/status structs between controller and datapath.
// No dependencies.
package uvst_pkg;

  localparam int CMD_W    = 1;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_ADD    = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                capture;
    logic                compare;
    logic                apply_add;
    logic                apply_del;
    logic                load_out;
    logic [STATUS_W-1:0] status;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic hit;
    logic full;
    logic is_remove;
  } dp_stat_t;

endpackage

// ----- sv/uvst_if.sv -----
// Handshake channel interfaces for the unique value set table.
// Depends on uvst_pkg for field widths.
interface uvst_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [uvst_pkg::CMD_W-1:0]           cmd;
  logic signed [uvst_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

interface uvst_out_if;
  logic                          valid;
  logic                          ready;
  logic [uvst_pkg::STATUS_W-1:0] status;
  logic [uvst_pkg::COUNT_W-1:0]  count;
  logic                          empty_res;

  modport source (output valid, output status, output count, output empty_res, input ready);
  modport sink (input valid, input status, input count, input empty_res, output ready);
endinterface

// ----- sv/unique_value_set_table_top.sv -----
// Top level of the unique value set table.
// Depends on uvst_pkg, uvst_in_if, uvst_out_if, uvst_ctrl and uvst_dp.
//
// Usage: each word on in_ch carries a command (add or remove) and a signed
// 32-bit value. Each accepted word yields exactly one word on out_ch with
// the status (done, refused, full), the count after the operation and an
// empty flag. Words are accepted when valid and ready are both high.
// Steps: the accepted word is captured, then compared in parallel across all
// cells, then the update step changes the table and loads the result
// register. A new word is accepted only once the previous one has passed
// the update step, as set by the compare and update steps of the
// controller; in_ch takes one word at a time.
// The result register parts the two sides: a new word is taken while the
// previous result waits. If out_ch stalls, the update step waits with the
// table unchanged until the result register is free.
// Reset: synchronous, active low; the count goes to zero and no result is
// pending. Cell contents are not cleared, as only cells below the count are
// read. CAPACITY sets the number of cells.
module unique_value_set_table_top #(
  parameter int CAPACITY = 16
) (
  input logic       clk,
  input logic       rst_n,
  uvst_in_if.sink   in_ch,
  uvst_out_if.source out_ch
);

  uvst_pkg::dp_cmd_t  dp_cmd;
  uvst_pkg::dp_stat_t dp_stat;

  uvst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  uvst_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_cmd       (in_ch.cmd),
    .in_value     (in_ch.value),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .out_status   (out_ch.status),
    .out_count    (out_ch.count),
    .out_empty_res(out_ch.empty_res)
  );

endmodule

// ----- sv/uvst_ctrl.sv -----
// Controller of the unique value set table: sequences compare and update,
// decides the status and owns the result valid flag. Depends on uvst_pkg.
module uvst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  uvst_pkg::dp_stat_t stat,
  output uvst_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  // The result register is free when empty or being taken this cycle.
  assign fire      = (state_r == S_UPD) && (!out_valid_r || out_ready);

  always_comb begin
    cmd           = '0;
    cmd.capture   = in_valid && in_ready;
    cmd.compare   = (state_r == S_CMP);
    cmd.load_out  = fire;
    if (stat.is_remove) begin
      cmd.status    = stat.hit ? uvst_pkg::ST_DONE : uvst_pkg::ST_REFUSED;
      cmd.apply_del = fire && stat.hit;
    end else if (stat.hit) begin
      cmd.status = uvst_pkg::ST_REFUSED;
    end else if (stat.full) begin
      cmd.status = uvst_pkg::ST_FULL;
    end else begin
      cmd.status    = uvst_pkg::ST_DONE;
      cmd.apply_add = fire;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_UPD;
      S_UPD:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/uvst_dp.sv -----
// Datapath of the unique value set table: the row of value cells with
// parallel compare and shift, the count and the result register. Depends on uvst_pkg.
module uvst_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [uvst_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [uvst_pkg::VALUE_W-1:0] in_value,
  input  uvst_pkg::dp_cmd_t                  cmd,
  output uvst_pkg::dp_stat_t                 stat,
  output logic [uvst_pkg::STATUS_W-1:0]      out_status,
  output logic [uvst_pkg::COUNT_W-1:0]       out_count,
  output logic                               out_empty_res
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [uvst_pkg::VALUE_W-1:0]  cell_r [CAPACITY];
  logic [CntW-1:0]               count_r, count_nxt;
  logic [uvst_pkg::CMD_W-1:0]    cmd_r;
  logic [uvst_pkg::VALUE_W-1:0]  value_r;
  logic                          hit_r;
  logic [IdxW-1:0]               pos_r;
  logic [uvst_pkg::STATUS_W-1:0] status_r;
  logic [uvst_pkg::COUNT_W-1:0]  res_count_r;
  logic                          empty_r;

  logic [CAPACITY-1:0] match;
  logic [IdxW-1:0]     match_pos;

  // Only cells below the count hold values; values are distinct, so at
  // most one cell matches and the position encode is a plain OR.
  always_comb begin
    match_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CntW'(i) < count_r) && (cell_r[i] == value_r);
      if (match[i]) match_pos = match_pos | IdxW'(i);
    end
  end

  always_comb begin
    if (cmd.apply_add) begin
      count_nxt = count_r + CntW'(1);
    end else if (cmd.apply_del) begin
      count_nxt = count_r - CntW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  assign stat.hit       = hit_r;
  assign stat.full      = (count_r == CntW'(CAPACITY));
  assign stat.is_remove = (cmd_r == uvst_pkg::CMD_REMOVE);

  assign out_status    = status_r;
  assign out_count     = res_count_r;
  assign out_empty_res = empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_cmd;
      value_r <= in_value;
    end
    if (cmd.compare) begin
      hit_r <= |match;
      pos_r <= match_pos;
    end
    if (cmd.load_out) begin
      status_r    <= cmd.status;
      res_count_r <= uvst_pkg::COUNT_W'(count_nxt);
      empty_r     <= (count_nxt == '0);
    end
  end

  // Add writes the cell at the count; remove pulls every cell at or
  // above the hit position but the last down from its upper neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i < CAPACITY - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.apply_add && (CntW'(i) == count_r)) begin
          cell_r[i] <= value_r;
        end else if (cmd.apply_del && (IdxW'(i) >= pos_r)) begin
          cell_r[i] <= cell_r[i+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.apply_add && (CntW'(i) == count_r)) begin
          cell_r[i] <= value_r;
        end
      end
    end
  end

endmodule

// ----- sv/uvst_checker.sv -----
// Port-level checker for the unique value set table and its bind to the
// top level. Depends on uvst_pkg.
module uvst_checker #(
  parameter int CAPACITY = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [uvst_pkg::STATUS_W-1:0] out_status,
  input logic [uvst_pkg::COUNT_W-1:0]  out_count,
  input logic                          out_empty_res
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count)
      && $stable(out_empty_res))
    else $error("result word changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == '0)))
    else $error("empty flag disagrees with count");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == uvst_pkg::ST_DONE || out_status == uvst_pkg::ST_REFUSED
      || out_status == uvst_pkg::ST_FULL) && (int'(out_count) <= CAPACITY))
    else $error("bad status or count above capacity");

  // A new result appears only after an accepted word.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result without a matching input word");

endmodule

bind unique_value_set_table_top uvst_checker #(
  .CAPACITY(CAPACITY)
) u_uvst_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_count    (out_ch.count),
  .out_empty_res(out_ch.empty_res)
);

// ----- tb/uvst_tb_pkg.sv -----
// Scoreboard for the unique value set table testbench: predicts each result
// from accepted input words and checks the words that come out.
// Depends on uvst_pkg for field widths, command and status codes.
`timescale 1ns / 100ps

package uvst_tb_pkg;
  import uvst_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                empty_res;
  } set_result_t;

  class set_table_scoreboard;
    int capacity;
    logic [VALUE_W-1:0] stored_values[$];
    set_result_t due_results[$];
    int mismatches;
    int adds_seen;
    int removes_seen;
    int status_seen[4];
    int peak_count;

    function new(int cap);
      capacity = cap;
      mismatches = 0;
      adds_seen = 0;
      removes_seen = 0;
      peak_count = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    // Applies one accepted word to the shadow table and queues its result.
    function void note_word(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
      set_result_t res;
      int hit_at;
      hit_at = -1;
      foreach (stored_values[i]) begin
        if (hit_at < 0 && stored_values[i] == value) hit_at = i;
      end
      if (cmd == CMD_ADD) begin
        adds_seen++;
        if (hit_at >= 0) begin
          res.status = ST_REFUSED;
        end else if (stored_values.size() >= capacity) begin
          res.status = ST_FULL;
        end else begin
          stored_values = {stored_values, value};
          res.status = ST_DONE;
        end
      end else begin
        removes_seen++;
        if (hit_at < 0) begin
          res.status = ST_REFUSED;
        end else begin
          // Deleting from the queue keeps the later entries in order.
          stored_values.delete(hit_at);
          res.status = ST_DONE;
        end
      end
      res.count = COUNT_W'(stored_values.size());
      res.empty_res = (stored_values.size() == 0);
      if (stored_values.size() > peak_count) peak_count = stored_values.size();
      status_seen[res.status]++;
      due_results = {due_results, res};
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count,
                               logic empty_res);
      set_result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with none due: status %0d count %0d empty %0d",
                                  status, count, empty_res));
        return;
      end
      want = due_results.pop_front();
      if (status !== want.status || count !== want.count || empty_res !== want.empty_res)
        report_mismatch($sformatf(
          "expected status %0d count %0d empty %0d, got status %0d count %0d empty %0d",
          want.status, want.count, want.empty_res, status, count, empty_res));
    endfunction

    function void close();
      if (due_results.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
// Top-level testbench for unique_value_set_table_top: directed and random
// add/remove words with random idling on both channels, checked against a
// scoreboard. Depends on uvst_pkg, the channel interfaces and uvst_tb_pkg.
`timescale 1ns / 100ps

module tb_top;
  import uvst_pkg::*;
  import uvst_tb_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int POOL_N      = 24;
  localparam int BLOCKS      = 15;
  localparam int BLOCK_WORDS = 100;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;

  uvst_in_if  in_ch();
  uvst_out_if out_ch();

  unique_value_set_table_top #(.CAPACITY(CAPACITY)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  set_table_scoreboard sb;
  logic [VALUE_W-1:0] pool[POOL_N];
  bit src_gaps_on;
  bit snk_gaps_on;
  int hold_req;
  int cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  function automatic void refresh_pool();
    foreach (pool[i]) pool[i] = $urandom;
    if ($urandom_range(1)) begin
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7fff_ffff;
      pool[2] = 32'h0000_0000;
      pool[3] = 32'hffff_ffff;
    end
  endfunction

  // A small pool makes repeats likely, so hits on add and remove are common.
  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(99) < 8) return $urandom;
    return pool[$urandom_range(POOL_N - 1)];
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(cmd, value);
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Holds the input off until every outstanding result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_directed();
    send_word(CMD_REMOVE, 32'd5);
    send_word(CMD_ADD, 32'h8000_0000);
    send_word(CMD_ADD, 32'h7fff_ffff);
    send_word(CMD_ADD, 32'h0000_0000);
    send_word(CMD_ADD, 32'hffff_ffff);
    send_word(CMD_ADD, 32'h7fff_ffff);
    send_word(CMD_REMOVE, 32'd12345);
    for (int i = 0; i < CAPACITY - 4; i++) begin
      send_word(CMD_ADD, 32'h0101_0000 * (i + 1) + i);
    end
    // The table is full now: an absent value reports full, a present one refused.
    send_word(CMD_ADD, 32'h5555_aaaa);
    send_word(CMD_ADD, 32'h0000_0000);
    send_word(CMD_REMOVE, 32'h0303_0002);
    send_word(CMD_REMOVE, 32'h8000_0000);
    send_word(CMD_REMOVE, 32'h0c0c_000b);
    send_word(CMD_ADD, 32'h8000_0000);
  endtask

  // Result side: random stalls, plus the long hold-off when one is requested.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end else if (stall_left == 0 && snk_gaps_on) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.status, out_ch.count, out_ch.empty_res);
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles", cycle_cnt);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int add_pct;
    logic [CMD_W-1:0] cmd;
    sb = new(CAPACITY);
    hold_req = 0;
    src_gaps_on = 1'b1;
    snk_gaps_on = 1'b1;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= CMD_ADD;
    in_ch.value <= '0;
    refresh_pool();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int blk = 0; blk < BLOCKS; blk++) begin
      case (blk % 5)
        0: add_pct = 85;
        1: add_pct = 50;
        2: add_pct = 15;
        3: add_pct = 60;
        default: add_pct = 95;
      endcase
      src_gaps_on = (blk % 3 != 2);
      snk_gaps_on = (blk % 4 != 1);
      if (blk % 4 == 0) refresh_pool();
      if (blk == 3) begin
        // Keep offering words back to back while the result side stalls.
        src_gaps_on = 1'b0;
        hold_req = 300;
      end
      if (blk == 7 || blk == 11) drain();
      for (int k = 0; k < BLOCK_WORDS; k++) begin
        cmd = ($urandom_range(99) < add_pct) ? CMD_ADD : CMD_REMOVE;
        send_word(cmd, pick_value());
        idle(src_gaps_on ? gap_len() : 0);
      end
    end

    drain();
    repeat (12) @(posedge clk);
    sb.close();
    $display("Ran %0d adds and %0d removes over %0d cycles, peak count %0d.",
             sb.adds_seen, sb.removes_seen, cycle_cnt, sb.peak_count);
    $display("Statuses seen: done %0d, refused %0d, full %0d; mismatches %0d.",
             sb.status_seen[ST_DONE], sb.status_seen[ST_REFUSED],
             sb.status_seen[ST_FULL], sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/uvst_pkg.sv
sv/uvst_if.sv
sv/uvst_ctrl.sv
sv/uvst_dp.sv
sv/unique_value_set_table_top.sv
sv/uvst_checker.sv
tb/uvst_tb_pkg.sv
tb/tb_top.sv
